>>> hdl/asml_pkg.sv
// ----------------------------------------------------------------------------
// asml_pkg: shared definitions for the armor select and mode lock core
// Angle format, CORDIC arctangent table, armor offset table, register
// indexes, aim mode codes, controller states and control interfaces.
// ----------------------------------------------------------------------------
package asml_pkg;

   localparam int MAX_ARMORS_DEF = 4;

   // Angles are radians times 8192.
   localparam int ANG_PI      = 25736;
   localparam int ANG_TWO_PI  = 51472;
   localparam int ANG_HALF_PI = 12868;

   localparam int ANGLE_W   = 15;   // configuration angles
   localparam int XY_W      = 27;   // CORDIC vector components
   localparam int Z_W       = 17;   // CORDIC angle accumulator
   localparam int WRAP_W    = 19;   // unwrapped armor angle
   localparam int DELTA_W   = 16;   // wrapped armor angle
   localparam int STEP_W    = 4;
   localparam int CORDIC_STEPS = 14;
   localparam int OFFSET_W  = 16;
   localparam int CSR_ADDR_W = 3;

   localparam logic [ANGLE_W-1:0] COMING_RESET  = 15'd8579;
   localparam logic [ANGLE_W-1:0] LEAVING_RESET = 15'd6434;

   // Register indexes, taken from byte address bit 2.
   localparam logic REG_COMING_ANGLE  = 1'b0;
   localparam logic REG_LEAVING_ANGLE = 1'b1;

   // Aim mode codes.
   localparam logic [1:0] MODE_SINGLE = 2'd0;
   localparam logic [1:0] MODE_WHOLE  = 2'd1;
   localparam logic [1:0] MODE_PAIR   = 2'd2;
   localparam logic [1:0] MODE_OTHER  = 2'd3;

   typedef logic [OFFSET_W-1:0] offset_row_type [0:7];

   // Armor offset i*2pi/N rounded to nearest, indexed by N then i (N up to 8).
   localparam offset_row_type ARMOR_OFFSET [0:8] = '{
      '{16'd0, 16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     16'd0},
      '{16'd0, 16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     16'd0},
      '{16'd0, 16'd25736, 16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     16'd0},
      '{16'd0, 16'd17157, 16'd34315, 16'd0,     16'd0,     16'd0,     16'd0,     16'd0},
      '{16'd0, 16'd12868, 16'd25736, 16'd38604, 16'd0,     16'd0,     16'd0,     16'd0},
      '{16'd0, 16'd10294, 16'd20589, 16'd30883, 16'd41178, 16'd0,     16'd0,     16'd0},
      '{16'd0, 16'd8579,  16'd17157, 16'd25736, 16'd34315, 16'd42893, 16'd0,     16'd0},
      '{16'd0, 16'd7353,  16'd14706, 16'd22059, 16'd29413, 16'd36766, 16'd44119, 16'd0},
      '{16'd0, 16'd6434,  16'd12868, 16'd19302, 16'd25736, 16'd32170, 16'd38604, 16'd45038}
   };

   function automatic logic [12:0] cordic_atan(input logic [STEP_W-1:0] step);
      logic [12:0] val;
      case (step)
         4'd0:    val = 13'd6434;
         4'd1:    val = 13'd3798;
         4'd2:    val = 13'd2007;
         4'd3:    val = 13'd1019;
         4'd4:    val = 13'd511;
         4'd5:    val = 13'd256;
         4'd6:    val = 13'd128;
         4'd7:    val = 13'd64;
         4'd8:    val = 13'd32;
         4'd9:    val = 13'd16;
         4'd10:   val = 13'd8;
         4'd11:   val = 13'd4;
         4'd12:   val = 13'd2;
         4'd13:   val = 13'd1;
         default: val = 13'd0;
      endcase
      return val;
   endfunction

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_CALC,
      ST_PICK,
      ST_FINISH
   } asml_state_type;

   typedef struct packed {
      logic              load;
      logic              rotate;
      logic [STEP_W-1:0] step;
      logic              calc;
      logic              pick;
      logic              commit;
   } asml_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic scan_last;
   } asml_status_type;

endpackage

>>> hdl/asml_csr.sv
// ----------------------------------------------------------------------------
// asml_csr: configuration registers
// Holds the coming and leaving angles behind a simple APB-style port.
// ----------------------------------------------------------------------------
module asml_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [asml_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready,
   output logic [asml_pkg::ANGLE_W-1:0]    coming_angle,
   output logic [asml_pkg::ANGLE_W-1:0]    leaving_angle
);
   import asml_pkg::*;

   logic [ANGLE_W-1:0] coming_ff, coming_in;
   logic [ANGLE_W-1:0] leaving_ff, leaving_in;
   logic               wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      coming_in  = coming_ff;
      leaving_in = leaving_ff;
      if (wr_en) begin
         if (csr_paddr[2] == REG_COMING_ANGLE) begin
            coming_in = csr_pwdata[ANGLE_W-1:0];
         end else begin
            leaving_in = csr_pwdata[ANGLE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coming_ff  <= COMING_RESET;
         leaving_ff <= LEAVING_RESET;
      end else begin
         coming_ff  <= coming_in;
         leaving_ff <= leaving_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_COMING_ANGLE) ? 32'(coming_ff) : 32'(leaving_ff);

   assign coming_angle  = coming_ff;
   assign leaving_angle = leaving_ff;

endmodule

>>> hdl/asml_ctrl.sv
// ----------------------------------------------------------------------------
// asml_ctrl: sequencing controller
// Steps one word through bearing rotation, the armor scan and the commit,
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module asml_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  asml_pkg::asml_status_type status,
   output asml_pkg::asml_cmd_type    cmd
);
   import asml_pkg::*;

   asml_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.step     = step_ff;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_ROTATE;
            end
         end
         ST_ROTATE: begin
            cmd.rotate = 1'b1;
            step_in    = step_ff + 1'b1;
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               state_in = status.count_zero ? ST_FINISH : ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_PICK;
         end
         ST_PICK: begin
            cmd.pick = 1'b1;
            state_in = status.scan_last ? ST_FINISH : ST_CALC;
         end
         ST_FINISH: begin
            // Hold the finished word until the output register is free.
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hdl/asml_datapath.sv
// ----------------------------------------------------------------------------
// asml_datapath: bearing, armor angles and selection
// A shared shift-add unit runs the vectoring CORDIC one step per cycle; the
// armor scan wraps each angle in a calc step and folds it into the selection
// trackers in a pick step. The commit resolves the mode and the lock.
// ----------------------------------------------------------------------------
module asml_datapath #(
   parameter int MAX_ARMORS = asml_pkg::MAX_ARMORS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  asml_pkg::asml_cmd_type       cmd,
   output asml_pkg::asml_status_type    status,
   input  logic signed [15:0]           req_center_x,
   input  logic signed [15:0]           req_center_y,
   input  logic signed [15:0]           req_car_yaw,
   input  logic signed [15:0]           req_spin_rate,
   input  logic [2:0]                   req_armor_count,
   input  logic [1:0]                   req_aim_mode,
   input  logic [asml_pkg::ANGLE_W-1:0] coming_angle,
   input  logic [asml_pkg::ANGLE_W-1:0] leaving_angle,
   output logic [1:0]                   rsp_armor_index
);
   import asml_pkg::*;

   localparam int IDX_W = (MAX_ARMORS > 1) ? $clog2(MAX_ARMORS) : 1;
   localparam int CNT_W = $clog2(MAX_ARMORS + 1);

   // Word registers
   logic signed [15:0]  yaw_ff;
   logic                spin_pos_ff, spin_neg_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [1:0]          mode_ff;
   logic [3:0]          count_sat;

   // CORDIC unit
   logic signed [XY_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]  z_ff, z_in;
   logic signed [XY_W-1:0] xs, ys, dx, dy;
   logic signed [Z_W-1:0]  atan_step;

   // Armor scan
   logic [IDX_W-1:0]          scan_ff;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic signed [WRAP_W-1:0]  raw_angle, wrapped;
   logic [OFFSET_W-1:0]       offset;
   logic [ANGLE_W-1:0]        abs_delta;
   logic                      in_coming, leave_ok;
   logic signed [DELTA_W:0]   delta_ext, leave_ext;

   // Selection trackers
   logic                 min_valid_ff;
   logic [IDX_W-1:0]     min_idx_ff;
   logic [ANGLE_W-1:0]   min_val_ff;
   logic                 pair_valid_ff;
   logic [IDX_W-1:0]     pair_idx_ff;
   logic [ANGLE_W-1:0]   pair_val_ff;
   logic [1:0]           cand_cnt_ff;
   logic [IDX_W-1:0]     cand_a_ff, cand_b_ff;
   logic [ANGLE_W-1:0]   cand_a_val_ff, cand_b_val_ff;
   logic                 whole_found_ff;
   logic [IDX_W-1:0]     whole_idx_ff;

   // Lock and result
   logic                 lock_valid_ff, lock_valid_in;
   logic [IDX_W-1:0]     lock_ff, lock_in;
   logic [IDX_W-1:0]     result;
   logic [IDX_W-1:0]     pair_winner;
   logic [1:0]           rsp_index_ff;

   assign count_sat = ({1'b0, req_armor_count} > 4'(MAX_ARMORS)) ?
                      4'(MAX_ARMORS) : {1'b0, req_armor_count};

   assign status.count_zero = (count_ff == '0);
   assign status.scan_last  = ((CNT_W'(scan_ff) + CNT_W'(1)) == count_ff);

   // Start vector: scaled by 256 and turned into the right half plane.
   always_comb begin
      xs = {{(XY_W - 24){req_center_x[15]}}, req_center_x, 8'b0};
      ys = {{(XY_W - 24){req_center_y[15]}}, req_center_y, 8'b0};
      dx = y_ff >>> cmd.step;
      dy = x_ff >>> cmd.step;
      atan_step = $signed({{(Z_W - 13){1'b0}}, cordic_atan(cmd.step)});
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (cmd.load) begin
         x_in = xs;
         y_in = ys;
         z_in = '0;
         if (req_center_x[15]) begin
            if (!req_center_y[15]) begin
               x_in = ys;
               y_in = -xs;
               z_in = Z_W'(ANG_HALF_PI);
            end else begin
               x_in = -ys;
               y_in = xs;
               z_in = -Z_W'(ANG_HALF_PI);
            end
         end
      end else if (cmd.rotate) begin
         if (y_ff > 0) begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + atan_step;
         end else if (y_ff < 0) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - atan_step;
         end
      end
   end

   // Armor angle relative to the bearing, wrapped into [-pi, pi).
   always_comb begin
      offset    = ARMOR_OFFSET[4'(count_ff)][3'(scan_ff)];
      raw_angle = WRAP_W'(yaw_ff) + $signed({{(WRAP_W - OFFSET_W){1'b0}}, offset})
                  - WRAP_W'(z_ff) + WRAP_W'(ANG_PI);
      if (raw_angle < 0) begin
         wrapped = raw_angle + WRAP_W'(ANG_TWO_PI);
      end else if (raw_angle >= WRAP_W'(2 * ANG_TWO_PI)) begin
         wrapped = raw_angle - WRAP_W'(2 * ANG_TWO_PI);
      end else if (raw_angle >= WRAP_W'(ANG_TWO_PI)) begin
         wrapped = raw_angle - WRAP_W'(ANG_TWO_PI);
      end else begin
         wrapped = raw_angle;
      end
      delta_in = DELTA_W'(wrapped - WRAP_W'(ANG_PI));
   end

   always_comb begin
      abs_delta = delta_ff[DELTA_W-1] ? ANGLE_W'(-delta_ff) : ANGLE_W'(delta_ff);
      in_coming = (abs_delta <= coming_angle);
      delta_ext = {delta_ff[DELTA_W-1], delta_ff};
      leave_ext = $signed({2'b0, leaving_angle});
      leave_ok  = (spin_pos_ff && (delta_ext < leave_ext)) ||
                  (spin_neg_ff && ((delta_ext + leave_ext) > 0));
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         yaw_ff      <= req_car_yaw;
         spin_pos_ff <= !req_spin_rate[15] && (req_spin_rate != '0);
         spin_neg_ff <= req_spin_rate[15];
         mode_ff     <= req_aim_mode;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      if (cmd.calc) begin
         delta_ff <= delta_in;
      end
      if (cmd.pick) begin
         if (!min_valid_ff || (abs_delta < min_val_ff)) begin
            min_idx_ff <= scan_ff;
            min_val_ff <= abs_delta;
         end
         if ((scan_ff[0] == spin_pos_ff) && (!pair_valid_ff || (abs_delta < pair_val_ff))) begin
            pair_idx_ff <= scan_ff;
            pair_val_ff <= abs_delta;
         end
         if (in_coming && (cand_cnt_ff == 2'd0)) begin
            cand_a_ff     <= scan_ff;
            cand_a_val_ff <= abs_delta;
         end
         if (in_coming && (cand_cnt_ff == 2'd1)) begin
            cand_b_ff     <= scan_ff;
            cand_b_val_ff <= abs_delta;
         end
         if (in_coming && leave_ok) begin
            whole_idx_ff <= scan_ff;
         end
      end
      if (cmd.commit) begin
         rsp_index_ff <= 2'(result);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         scan_ff        <= '0;
         min_valid_ff   <= 1'b0;
         pair_valid_ff  <= 1'b0;
         cand_cnt_ff    <= 2'd0;
         whole_found_ff <= 1'b0;
         lock_valid_ff  <= 1'b0;
         lock_ff        <= '0;
      end else begin
         lock_valid_ff <= lock_valid_in;
         lock_ff       <= lock_in;
         if (cmd.load) begin
            count_ff       <= count_sat[CNT_W-1:0];
            scan_ff        <= '0;
            min_valid_ff   <= 1'b0;
            pair_valid_ff  <= 1'b0;
            cand_cnt_ff    <= 2'd0;
            whole_found_ff <= 1'b0;
         end else if (cmd.pick) begin
            scan_ff      <= scan_ff + 1'b1;
            min_valid_ff <= 1'b1;
            if (scan_ff[0] == spin_pos_ff) begin
               pair_valid_ff <= 1'b1;
            end
            if (in_coming && (cand_cnt_ff != 2'd2)) begin
               cand_cnt_ff <= cand_cnt_ff + 2'd1;
            end
            if (in_coming && leave_ok) begin
               whole_found_ff <= 1'b1;
            end
         end
      end
   end

   // Final choice for the word and the sticky lock of single armor mode.
   always_comb begin
      lock_valid_in = lock_valid_ff;
      lock_in       = lock_ff;
      pair_winner   = (cand_a_val_ff < cand_b_val_ff) ? cand_a_ff : cand_b_ff;
      result        = min_idx_ff;
      if (count_ff == '0) begin
         result = '0;
      end else begin
         case (mode_ff)
            MODE_SINGLE: begin
               if (cand_cnt_ff == 2'd2) begin
                  if (lock_valid_ff && ((lock_ff == cand_a_ff) || (lock_ff == cand_b_ff))) begin
                     result = lock_ff;
                  end else begin
                     result = pair_winner;
                  end
                  if (cmd.commit) begin
                     lock_valid_in = 1'b1;
                     lock_in       = result;
                  end
               end else if (cand_cnt_ff == 2'd1) begin
                  result = cand_a_ff;
                  if (cmd.commit) begin
                     lock_valid_in = 1'b0;
                  end
               end
            end
            MODE_WHOLE: begin
               if (whole_found_ff) begin
                  result = whole_idx_ff;
               end
            end
            MODE_PAIR: begin
               if (4'(count_ff) == 4'd4) begin
                  result = pair_idx_ff;
               end
            end
            MODE_OTHER: begin
               result = min_idx_ff;
            end
            default: begin
               result = min_idx_ff;
            end
         endcase
      end
   end

   assign rsp_armor_index = rsp_index_ff;

endmodule

>>> hdl/armor_select_mode_lock_core.sv
// ----------------------------------------------------------------------------
// armor_select_mode_lock_core: armor plate selector for a spinning target
// Top level joining the configuration registers, the controller and the
// datapath.
// ----------------------------------------------------------------------------
// One word is taken at a time: after acceptance the shared shift-add CORDIC
// unit finds the bearing, then the armor scan, skipped when the count is
// zero, wraps each armor angle and folds it into the selection, and the
// result is committed before the next word is accepted. A new word is
// accepted while the previous result still waits in the output register.
// Counts above MAX_ARMORS saturate, and single armor mode keeps its lock
// across words until a word with exactly one candidate clears it.
module armor_select_mode_lock_core #(
   parameter int MAX_ARMORS = asml_pkg::MAX_ARMORS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [15:0]              req_center_x,
   input  logic signed [15:0]              req_center_y,
   input  logic signed [15:0]              req_car_yaw,
   input  logic signed [15:0]              req_spin_rate,
   input  logic [2:0]                      req_armor_count,
   input  logic [1:0]                      req_aim_mode,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_armor_index,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [asml_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import asml_pkg::*;

   asml_cmd_type       cmd;
   asml_status_type    status;
   logic [ANGLE_W-1:0] coming_angle;
   logic [ANGLE_W-1:0] leaving_angle;

   asml_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .coming_angle  (coming_angle),
      .leaving_angle (leaving_angle)
   );

   asml_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   asml_datapath #(
      .MAX_ARMORS (MAX_ARMORS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_center_x    (req_center_x),
      .req_center_y    (req_center_y),
      .req_car_yaw     (req_car_yaw),
      .req_spin_rate   (req_spin_rate),
      .req_armor_count (req_armor_count),
      .req_aim_mode    (req_aim_mode),
      .coming_angle    (coming_angle),
      .leaving_angle   (leaving_angle),
      .rsp_armor_index (rsp_armor_index)
   );

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: armor select and mode lock core
// Drives target words through the request channel with random idling on both
// channels, predicts each chosen armor plate from the bearing and the sticky
// lock, and compares every result word in order. The angle registers are
// written between phases and read back.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import asml_pkg::*;

   localparam int     ARMOR_LIMIT  = 4;
   localparam longint PI_Q13       = 25736;
   localparam longint TWO_PI_Q13   = 51472;
   localparam longint HALF_PI_Q13  = 12868;
   localparam int     SETTLE       = 40;
   localparam int     CYCLE_LIMIT  = 400000;
   localparam int     ATAN_Q13 [0:13] = '{6434, 3798, 2007, 1019, 511, 256, 128,
                                           64, 32, 16, 8, 4, 2, 1};

   typedef struct packed {
      logic signed [15:0] center_x;
      logic signed [15:0] center_y;
      logic signed [15:0] car_yaw;
      logic signed [15:0] spin_rate;
      logic [2:0]         armor_count;
      logic [1:0]         aim_mode;
   } target_word_type;

   typedef struct packed {
      target_word_type word;
      logic            known;
      logic [1:0]      index;
   } stim_row_type;

   typedef longint angle_set_type [ARMOR_LIMIT];

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic signed [15:0]    req_center_x;
   logic signed [15:0]    req_center_y;
   logic signed [15:0]    req_car_yaw;
   logic signed [15:0]    req_spin_rate;
   logic [2:0]            req_armor_count;
   logic [1:0]            req_aim_mode;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [1:0]            rsp_armor_index;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // Predictor state: the register copies and the single armor lock.
   longint coming_q13;
   longint leaving_q13;
   int     locked_slot;

   logic [1:0]   pending_index [$];
   stim_row_type directed_rows [$];
   int           mismatches = 0;
   int           results_seen = 0;
   bit           quiet = 1'b0;

   armor_select_mode_lock_core #(
      .MAX_ARMORS(ARMOR_LIMIT)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_center_x    (req_center_x),
      .req_center_y    (req_center_y),
      .req_car_yaw     (req_car_yaw),
      .req_spin_rate   (req_spin_rate),
      .req_armor_count (req_armor_count),
      .req_aim_mode    (req_aim_mode),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_armor_index (rsp_armor_index),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void report_mismatch(input string what, input int want, input int got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch in %s: expected %0d, got %0d", what, want, got);
      end
   endfunction

   function automatic longint mag(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint wrap_q13(input longint a);
      longint r;
      r = (a + PI_Q13) % TWO_PI_Q13;
      if (r < 0) begin
         r += TWO_PI_Q13;
      end
      return r - PI_Q13;
   endfunction

   // Vectoring CORDIC on the centre scaled by 256; arithmetic shifts round down.
   function automatic longint center_bearing(input longint x, input longint y);
      longint xs, ys, z, t, dx, dy;
      int     i;
      xs = x * 256;
      ys = y * 256;
      z  = 0;
      if (x == 0 && y == 0) begin
         return 0;
      end
      if (xs < 0) begin
         t = xs;
         if (ys >= 0) begin
            xs = ys;
            ys = -t;
            z  = HALF_PI_Q13;
         end else begin
            xs = -ys;
            ys = t;
            z  = -HALF_PI_Q13;
         end
      end
      for (i = 0; i < 14; i++) begin
         dx = ys >>> i;
         dy = xs >>> i;
         if (ys > 0) begin
            xs += dx;
            ys -= dy;
            z  += longint'(ATAN_Q13[i]);
         end else if (ys < 0) begin
            xs -= dx;
            ys += dy;
            z  -= longint'(ATAN_Q13[i]);
         end
      end
      return z;
   endfunction

   // Smallest absolute angle among the visited armors, first index on ties.
   function automatic int closest_armor(input angle_set_type ang, input int first,
                                        input int stop, input int stride);
      int     best, i;
      longint bv;
      best = first;
      bv   = mag(ang[first]);
      for (i = first + stride; i < stop; i += stride) begin
         if (mag(ang[i]) < bv) begin
            bv   = mag(ang[i]);
            best = i;
         end
      end
      return best;
   endfunction

   // Chooses the armor plate for one word and moves the lock as the block does.
   function automatic logic [1:0] select_armor(input target_word_type w);
      angle_set_type ang;
      longint        bear, off, spin;
      int            n, i, pick, a, b;
      n    = int'(w.armor_count);
      spin = longint'($signed(w.spin_rate));
      if (n > ARMOR_LIMIT) begin
         n = ARMOR_LIMIT;
      end
      if (n == 0) begin
         return 2'd0;
      end
      bear = center_bearing(longint'($signed(w.center_x)), longint'($signed(w.center_y)));
      for (i = 0; i < ARMOR_LIMIT; i++) begin
         ang[i] = 0;
      end
      for (i = 0; i < n; i++) begin
         off    = (longint'(i) * TWO_PI_Q13 + longint'(n / 2)) / longint'(n);
         ang[i] = wrap_q13(longint'($signed(w.car_yaw)) + off - bear);
      end
      pick = 0;
      if (w.aim_mode == MODE_SINGLE) begin
         a = -1;
         b = -1;
         for (i = 0; i < n; i++) begin
            if (mag(ang[i]) <= coming_q13) begin
               if (a < 0) begin
                  a = i;
               end else if (b < 0) begin
                  b = i;
               end
            end
         end
         if (b >= 0) begin
            if (locked_slot != a && locked_slot != b) begin
               locked_slot = (mag(ang[a]) < mag(ang[b])) ? a : b;
            end
            pick = locked_slot;
         end else if (a >= 0) begin
            locked_slot = -1;
            pick = a;
         end else begin
            pick = closest_armor(ang, 0, n, 1);
         end
      end else if (w.aim_mode == MODE_WHOLE) begin
         pick = -1;
         for (i = 0; i < n; i++) begin
            if (mag(ang[i]) <= coming_q13) begin
               if (spin > 0 && ang[i] < leaving_q13) begin
                  pick = i;
               end
               if (spin < 0 && ang[i] > -leaving_q13) begin
                  pick = i;
               end
            end
         end
         if (pick < 0) begin
            pick = closest_armor(ang, 0, n, 1);
         end
      end else if (w.aim_mode == MODE_PAIR && n == 4) begin
         pick = closest_armor(ang, (spin > 0) ? 1 : 0, 4, 2);
      end else begin
         pick = closest_armor(ang, 0, n, 1);
      end
      return 2'(pick);
   endfunction

   function automatic target_word_type random_target();
      target_word_type w;
      if ($urandom_range(0, 3) == 0) begin
         w.center_x = 16'($urandom_range(0, 200) - 100);
         w.center_y = 16'($urandom_range(0, 200) - 100);
      end else begin
         w.center_x = 16'($urandom());
         w.center_y = 16'($urandom());
      end
      w.car_yaw   = 16'(int'($urandom_range(0, 51472)) - 25736);
      w.spin_rate = ($urandom_range(0, 7) == 0) ? 16'sd0 : 16'($urandom());
      w.armor_count = ($urandom_range(0, 1) == 0) ? 3'd4 : 3'($urandom_range(0, 7));
      w.aim_mode  = 2'($urandom_range(0, 3));
      return w;
   endfunction

   task automatic add_row(input int x, input int y, input int yaw, input int spin,
                          input int n, input logic [1:0] mode, input bit known,
                          input int want);
      stim_row_type r;
      r.word.center_x    = 16'(x);
      r.word.center_y    = 16'(y);
      r.word.car_yaw     = 16'(yaw);
      r.word.spin_rate   = 16'(spin);
      r.word.armor_count = 3'(n);
      r.word.aim_mode    = mode;
      r.known            = known;
      r.index            = 2'(want);
      directed_rows.insert(directed_rows.size(), r);
   endtask

   // Offers one word, holds it until accepted and queues the expected index.
   task automatic send_word(input target_word_type w, input bit known,
                            input logic [1:0] typed_index);
      logic [1:0] predicted;
      if (!quiet && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_center_x    <= w.center_x;
      req_center_y    <= w.center_y;
      req_car_yaw     <= w.car_yaw;
      req_spin_rate   <= w.spin_rate;
      req_armor_count <= w.armor_count;
      req_aim_mode    <= w.aim_mode;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = select_armor(w);
      pending_index.insert(pending_index.size(), known ? typed_index : predicted);
   endtask

   // Mostly runs of words from one spinning car so that the lock gets exercised.
   task automatic run_random(input int count);
      target_word_type w;
      longint          yaw, step;
      int              left, run_len, k;
      left = count;
      while (left > 0) begin
         if ($urandom_range(0, 3) != 0) begin
            w       = random_target();
            run_len = $urandom_range(4, 14);
            step    = longint'($urandom_range(100, 4000));
            if ($urandom_range(0, 1) == 0) begin
               step = -step;
            end
            w.spin_rate = (step > 0) ? 16'($urandom_range(1, 32767))
                                     : 16'(-int'($urandom_range(1, 32768)));
            if ($urandom_range(0, 9) == 0) begin
               w.spin_rate = 16'sd0;
            end
            if ($urandom_range(0, 4) != 0) begin
               w.armor_count = 3'd4;
               w.aim_mode    = 2'($urandom_range(0, 2));
            end
            yaw = longint'($signed(w.car_yaw));
            for (k = 0; k < run_len && left > 0; k++) begin
               w.car_yaw = 16'(yaw);
               send_word(w, 1'b0, 2'd0);
               left--;
               yaw = wrap_q13(yaw + step);
            end
         end else begin
            send_word(random_target(), 1'b0, 2'd0);
            left--;
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_index.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Write then read back one angle register; both transfers are back to back.
   task automatic write_angle(input logic reg_sel, input logic [14:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= {17'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (reg_sel == REG_COMING_ANGLE) begin
         coming_q13 = longint'(value);
      end else begin
         leaving_q13 = longint'(value);
      end
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== {17'd0, value}) begin
         report_mismatch("angle register readback", int'(value), int'(csr_prdata));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         results_seen++;
         if (pending_index.size() == 0) begin
            report_mismatch("armor_index with no word pending", -1, int'(rsp_armor_index));
         end else begin
            if (rsp_armor_index !== pending_index[0]) begin
               report_mismatch($sformatf("armor_index of result %0d", results_seen),
                               int'(pending_index[0]), int'(rsp_armor_index));
            end
            pending_index.delete(0);
         end
      end
   end

   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (quiet || $urandom_range(0, 19) != 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int k;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_center_x    <= '0;
      req_center_y    <= '0;
      req_car_yaw     <= '0;
      req_spin_rate   <= '0;
      req_armor_count <= '0;
      req_aim_mode    <= MODE_SINGLE;
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      csr_paddr       <= '0;
      csr_pwdata      <= '0;
      coming_q13  = 8579;
      leaving_q13 = 6434;
      locked_slot = -1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // No armors, plain bearings and the wrap at minus pi.
      add_row(0, 0, 0, 0, 0, MODE_SINGLE, 1'b1, 0);
      add_row(32767, -32768, 25736, 32767, 0, MODE_WHOLE, 1'b1, 0);
      add_row(1000, 0, 0, 100, 4, MODE_OTHER, 1'b1, 0);
      add_row(0, 0, 12868, -5, 4, MODE_OTHER, 1'b1, 3);
      add_row(1000, 0, -25736, 1, 4, MODE_OTHER, 1'b1, 2);
      add_row(3000, 0, 0, 0, 1, MODE_SINGLE, 1'b1, 0);
      // The lock is taken on a tie, held while the other plate is closer,
      // cleared by a single candidate and then taken afresh.
      add_row(1000, 0, 6434, 10, 4, MODE_SINGLE, 1'b0, 0);
      add_row(1000, 0, 5000, 10, 4, MODE_SINGLE, 1'b0, 0);
      add_row(1000, 0, 0, 10, 4, MODE_SINGLE, 1'b0, 0);
      add_row(1000, 0, 5000, 10, 4, MODE_SINGLE, 1'b0, 0);
      // Centres behind the shooter on both sides, and the field extremes.
      add_row(-32768, 0, -25736, -32768, 4, MODE_SINGLE, 1'b0, 0);
      add_row(-32768, -32768, 25736, 32767, 4, MODE_SINGLE, 1'b0, 0);
      add_row(32767, 32767, 0, 1, 4, MODE_SINGLE, 1'b0, 0);
      add_row(500, -700, 3000, 0, 4, MODE_SINGLE, 1'b0, 0);
      // Whole car mode with both spin signs and zero spin.
      add_row(2000, 1500, -8000, 1, 4, MODE_WHOLE, 1'b0, 0);
      add_row(2000, 1500, -8000, -1, 4, MODE_WHOLE, 1'b0, 0);
      add_row(2000, 1500, -8000, 0, 4, MODE_WHOLE, 1'b0, 0);
      // Pair mode with four plates, zero spin, and a count other than four.
      add_row(-1200, 800, 9000, 1, 4, MODE_PAIR, 1'b0, 0);
      add_row(-1200, 800, 9000, 0, 4, MODE_PAIR, 1'b0, 0);
      add_row(-1200, -800, 9000, -300, 3, MODE_PAIR, 1'b0, 0);
      add_row(-32768, 32767, -25736, 32767, 4, MODE_PAIR, 1'b0, 0);
      // Counts above the limit saturate to four plates; counts of two and three follow.
      add_row(0, -1, 100, 5, 7, MODE_OTHER, 1'b0, 0);
      add_row(1, 0, 0, 0, 5, MODE_SINGLE, 1'b0, 0);
      add_row(-1, 0, 20000, 7, 6, MODE_WHOLE, 1'b0, 0);
      add_row(3000, 200, -20000, -1, 2, MODE_SINGLE, 1'b0, 0);
      add_row(0, 5000, 4000, -32768, 3, MODE_WHOLE, 1'b0, 0);

      for (k = 0; k < directed_rows.size(); k++) begin
         send_word(directed_rows[k].word, directed_rows[k].known, directed_rows[k].index);
      end
      drain();

      write_angle(REG_COMING_ANGLE, 15'd0);
      write_angle(REG_LEAVING_ANGLE, 15'd0);
      run_random(100);
      drain();

      write_angle(REG_COMING_ANGLE, 15'd25736);
      write_angle(REG_LEAVING_ANGLE, 15'd25736);
      run_random(100);
      drain();

      write_angle(REG_COMING_ANGLE, 15'($urandom_range(0, 25736)));
      write_angle(REG_LEAVING_ANGLE, 15'($urandom_range(0, 25736)));
      run_random(100);
      drain();

      // The last phase runs without idling on either channel.
      quiet = 1'b1;
      write_angle(REG_COMING_ANGLE, 15'($urandom_range(4000, 25736)));
      write_angle(REG_LEAVING_ANGLE, 15'($urandom_range(0, 12000)));
      run_random(150);
      drain();

      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
